// ===== hw/rtl/pkvd_pkg.sv =====
// ----------------------------------------------------------------------------
// pkvd_pkg: shared constants for the paged kv element dequantizer
// Layout constants of the paged cache, field widths and reset values.
// ----------------------------------------------------------------------------
package pkvd_pkg;

  localparam int unsigned PageTokens = 64;
  localparam int unsigned RowBytes   = 576;
  localparam int unsigned Fp8Dims    = 448;
  localparam int unsigned TotalDims  = 512;
  localparam int unsigned ScaleBytes = 8;
  localparam int unsigned BlockDims  = 64;

  localparam int unsigned AddrW   = 38;
  localparam int unsigned LocW    = 24;
  localparam int unsigned DimW    = 9;
  localparam int unsigned StrideW = 20;
  localparam int unsigned OffW    = $clog2(PageTokens);
  localparam int unsigned PageW   = LocW - OffW;

  localparam logic [StrideW-1:0] StrideReset = 20'd37376;
  localparam logic [15:0]        Bf16QNan    = 16'h7FC0;

  // scale region base inside a page
  localparam logic [AddrW-1:0] ScaleBase = AddrW'(PageTokens * RowBytes);

endpackage

// ===== hw/rtl/pkvd_addr.sv =====
// ----------------------------------------------------------------------------
// pkvd_addr: address pipeline
// Three stages: page multiply, row offset add, final data/scale address add.
// ----------------------------------------------------------------------------
module pkvd_addr
  import pkvd_pkg::*;
(
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [LocW-1:0]    loc_i,
  input  logic [DimW-1:0]    dim_i,
  input  logic [StrideW-1:0] stride_i,
  output logic [AddrW-1:0]   data_addr_o,
  output logic [AddrW-1:0]   scale_addr_o
);

  logic [AddrW-1:0] base_q, row_q, scl_q, doff_q, soff_q;
  logic [OffW-1:0]  off_q;
  logic [DimW-1:0]  dim_q;
  logic             fp8_q;
  logic [AddrW-1:0] doff_d, soff_d;

  // stage 1: page base product
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      base_q <= AddrW'(loc_i[LocW-1:OffW]) * AddrW'(stride_i);
      off_q  <= loc_i[OffW-1:0];
      dim_q  <= dim_i;
    end
  end

  // dim dependent offsets
  always_comb begin
    if (dim_q < DimW'(Fp8Dims)) begin
      doff_d = AddrW'(dim_q);
      soff_d = AddrW'(dim_q / BlockDims);
    end else begin
      doff_d = AddrW'(Fp8Dims) + (AddrW'(dim_q - DimW'(Fp8Dims)) << 1);
      soff_d = '0;
    end
  end

  // stage 2: row and scale row
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      row_q   <= base_q + AddrW'(off_q) * AddrW'(RowBytes);
      scl_q   <= base_q + ScaleBase + AddrW'(off_q) * AddrW'(ScaleBytes);
      doff_q  <= doff_d;
      soff_q  <= soff_d;
      fp8_q   <= (dim_q < DimW'(Fp8Dims));
    end
  end

  // stage 3: final addresses
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_addr_o  <= row_q + doff_q;
      scale_addr_o <= fp8_q ? (scl_q + soff_q) : '0;
    end
  end

endmodule

// ===== hw/rtl/pkvd_value.sv =====
// ----------------------------------------------------------------------------
// pkvd_value: value pipeline
// Three stages: decode fields, scale exponent, round/pack bfloat16.
// ----------------------------------------------------------------------------
module pkvd_value
  import pkvd_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic        fp8_i,
  input  logic [7:0]  lo_i,
  input  logic [7:0]  hi_i,
  input  logic [7:0]  scale_i,
  output logic [15:0] value_o
);

  // stage 1 regs
  logic        nan_q, zero_q, sgn_q, pass_q;
  logic [3:0]  mag_q;
  logic [10:0] e_q;      // signed exponent of mag lsb
  logic [15:0] pv_q;
  // stage 2 regs
  logic        nan2_q, zero2_q, sgn2_q, pass2_q;
  logic [15:0] pv2_q;
  logic [3:0]  mag2_q;
  logic [10:0] top2_q;
  logic [1:0]  p2_q;

  // stage 1: decode
  logic [3:0]  ex;
  logic [2:0]  man;
  logic [15:0] pv;
  always_comb begin
    ex  = lo_i[6:3];
    man = lo_i[2:0];
    pv  = {hi_i, lo_i};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pass_q <= !fp8_i;
      pv_q   <= pv;
      sgn_q  <= lo_i[7];
      nan_q  <= fp8_i ? ((ex == 4'hF && man == 3'd7) || scale_i == 8'hFF)
                      : ((pv[14:7] == 8'hFF) && (pv[6:0] != '0));
      mag_q  <= (ex == '0) ? {1'b0, man} : {1'b1, man};
      zero_q <= (ex == '0) && (man == '0);
      e_q    <= ((ex == '0) ? -11'sd9 : 11'(ex) - 11'sd10)
                + 11'(scale_i) - 11'sd127;
    end
  end

  // stage 2: leading one and top exponent
  logic [1:0] p;
  always_comb begin
    priority if (mag_q[3]) p = 2'd3;
    else if (mag_q[2])     p = 2'd2;
    else if (mag_q[1])     p = 2'd1;
    else                   p = 2'd0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nan2_q  <= nan_q;
      zero2_q <= zero_q;
      sgn2_q  <= sgn_q;
      pass2_q <= pass_q;
      pv2_q   <= pv_q;
      mag2_q  <= mag_q;
      p2_q    <= p;
      top2_q  <= e_q + 11'(p);
    end
  end

  // stage 3: float32 pattern and bf16 rounding
  logic [31:0] f32;
  logic [32:0] rnd;
  logic [15:0] v;
  logic [10:0] sh;
  always_comb begin
    sh = top2_q - 11'(p2_q) + 11'sd149;
    if ($signed(top2_q) >= 11'sd128) begin
      f32 = 32'h7F80_0000;
    end else if ($signed(top2_q) >= -11'sd126) begin
      f32 = {1'b0, 8'(top2_q + 11'sd127),
             23'((32'(mag2_q) << (5'd23 - 5'(p2_q))) & 32'h007F_FFFF)};
    end else if ($signed(sh) < 0 || sh > 11'd31) begin
      f32 = '0;
    end else begin
      f32 = 32'(mag2_q) << sh[4:0];
    end
    rnd = 33'(f32) + 33'h7FFF + 33'(f32[16]);
    if (nan2_q)       v = Bf16QNan;
    else if (pass2_q) v = pv2_q;
    else if (zero2_q) v = {sgn2_q, 15'd0};
    else              v = {sgn2_q, rnd[30:16]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) value_o <= v;
  end

endmodule

// ===== hw/rtl/paged_fp8_kv_element_dequant.sv =====
// ----------------------------------------------------------------------------
// paged_fp8_kv_element_dequant: paged kv cache element dequantizer
// Computes element and scale byte addresses and the bfloat16 element value.
// ----------------------------------------------------------------------------
// Usage:
//   input channel: valid_i/stall_o with loc_i, dim_i, elem_lo_i, elem_hi_i,
//   scale_exp_i. output channel: valid_o/stall_i with data_addr_o,
//   scale_addr_o, value_bits_o. One result per input transfer.
//   The page stride register is written through cfg_we_i/cfg_wdata_i;
//   the user writes it only while idle, which the block does not enforce.
//   Each result moves through every pipe stage before valid_o rises.
//   Throughput is one item per cycle while the receiver does not stall,
//   set by the three-stage address and value pipes
//   (page multiply, row add, final add / decode, exponent, round).
//   The whole pipe advances as one: when the receiver stalls, the pipe
//   freezes only if the output stage holds an item and keeps moving
//   otherwise, so nothing is lost or repeated.
//   Reset clears all valid bits and sets the page stride to 37376.
// ----------------------------------------------------------------------------
module paged_fp8_kv_element_dequant
  import pkvd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [StrideW-1:0] cfg_wdata_i,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [LocW-1:0]    loc_i,
  input  logic [DimW-1:0]    dim_i,
  input  logic [7:0]         elem_lo_i,
  input  logic [7:0]         elem_hi_i,
  input  logic [7:0]         scale_exp_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic [AddrW-1:0]   data_addr_o,
  output logic [AddrW-1:0]   scale_addr_o,
  output logic [15:0]        value_bits_o
);

  logic [StrideW-1:0] stride_q;
  logic [2:0]         vld_q;
  logic               en;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) stride_q <= StrideReset;
    else if (cfg_we_i) stride_q <= cfg_wdata_i;
  end

  // pipe advance
  assign en      = !(vld_q[2] && stall_i);
  assign stall_o = !en;
  assign valid_o = vld_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[1:0], valid_i};
  end

  pkvd_addr u_addr (
    .clk_i,
    .en_i         (en),
    .loc_i,
    .dim_i,
    .stride_i     (stride_q),
    .data_addr_o,
    .scale_addr_o
  );

  pkvd_value u_value (
    .clk_i,
    .en_i    (en),
    .fp8_i   (dim_i < DimW'(Fp8Dims)),
    .lo_i    (elem_lo_i),
    .hi_i    (elem_hi_i),
    .scale_i (scale_exp_i),
    .value_o (value_bits_o)
  );

endmodule

// ===== hw/rtl/pkvd_checker.sv =====
// ----------------------------------------------------------------------------
// pkvd_checker: port level checks
// Observes the top level ports only; bound to the top level.
// ----------------------------------------------------------------------------
module pkvd_checker
  import pkvd_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             valid_i,
  input logic             stall_o,
  input logic             valid_o,
  input logic             stall_i,
  input logic [AddrW-1:0] data_addr_o,
  input logic [15:0]      value_bits_o
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(value_bits_o) && $stable(data_addr_o))
    else $error("stalled result changed");

  // input stall only with a held output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i)
    else $error("stall without blocked output");

  // a transfer through an open pipe appears at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !stall_o ##1 !stall_o ##1 !stall_o |=> valid_o)
    else $error("item lost in pipe");

  // nan output is canonical
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && value_bits_o[14:7] == 8'hFF && value_bits_o[6:0] != '0
      |-> value_bits_o == Bf16QNan)
    else $error("non canonical nan");

endmodule

bind paged_fp8_kv_element_dequant pkvd_checker u_pkvd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .valid_i      (valid_i),
  .stall_o      (stall_o),
  .valid_o      (valid_o),
  .stall_i      (stall_i),
  .data_addr_o  (data_addr_o),
  .value_bits_o (value_bits_o)
);

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: paged kv element dequantizer
// Drives element transfers with bursty valid and patterned stall, predicts
// addresses and bfloat16 values, and checks each result in order.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [37:0] data_addr;
  logic [37:0] scale_addr;
  logic [15:0] value_bits;
} elem_result_t;

class dequant_scoreboard;
  elem_result_t pending[$];
  int unsigned  mismatches;

  function void note_input(elem_result_t r);
    pending.push_back(r);
  endfunction

  function void check_result(elem_result_t got);
    elem_result_t want;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected %h %h %h actual %h %h %h",
                 want.data_addr, want.scale_addr, want.value_bits,
                 got.data_addr, got.scale_addr, got.value_bits);
    end
  endfunction
endclass

module testbench;
  import pkvd_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [StrideW-1:0] cfg_wdata_i = '0;
  logic               valid_i = 1'b0;
  logic               stall_o;
  logic [LocW-1:0]    loc_i = '0;
  logic [DimW-1:0]    dim_i = '0;
  logic [7:0]         elem_lo_i = '0;
  logic [7:0]         elem_hi_i = '0;
  logic [7:0]         scale_exp_i = '0;
  logic               valid_o;
  logic               stall_i = 1'b0;
  logic [AddrW-1:0]   data_addr_o;
  logic [AddrW-1:0]   scale_addr_o;
  logic [15:0]        value_bits_o;

  dequant_scoreboard sb = new();
  logic [StrideW-1:0] stride_model = StrideReset;
  int unsigned        cycles = 0;
  bit                 hold_off = 1'b0;

  paged_fp8_kv_element_dequant dut (.*);

  initial forever #1 clk_i = ~clk_i;

  // round a float32 pattern to bfloat16, nearest-even
  function automatic logic [15:0] round_bf16(logic [31:0] f);
    logic [32:0] sum;
    if (f[30:23] == 8'hFF && f[22:0] != 0) return Bf16QNan;
    sum = {1'b0, f} + 33'h7FFF + f[16];
    return sum[31:16];
  endfunction

  // bfloat16 of an fp8 e4m3 code scaled by 2^(scale-127)
  function automatic logic [15:0] fp8_to_bf16(logic [7:0] code, logic [7:0] scale);
    logic [3:0]  mag;
    int          e, p, top;
    logic [31:0] f;
    if (code[6:0] == 7'h7F || scale == 8'hFF) return Bf16QNan;
    if (code[6:3] == 0) begin
      mag = {1'b0, code[2:0]};
      e = -9;
    end else begin
      mag = {1'b1, code[2:0]};
      e = int'(code[6:3]) - 10;
    end
    if (mag == 0) return {code[7], 15'd0};
    e = e + int'(scale) - 127;
    p = 3;
    while (p > 0 && !mag[p]) p--;
    top = e + p;
    if (top >= 128) f = 32'h7F800000;
    else if (top >= -126)
      f = (32'(top + 127) << 23) | ((32'(mag) - (32'd1 << p)) << (23 - p));
    else f = 32'(mag) << (e + 149);
    return {code[7], 15'd0} | round_bf16(f);
  endfunction

  // full prediction of one element transfer
  function automatic elem_result_t predict_element(logic [23:0] loc, logic [8:0] dim,
                                                   logic [7:0] lo, logic [7:0] hi,
                                                   logic [7:0] scale);
    elem_result_t r;
    logic [63:0]  base, row;
    logic [15:0]  v;
    base = 64'(loc / PageTokens) * 64'(stride_model);
    row  = base + 64'(loc % PageTokens) * RowBytes;
    if (dim < Fp8Dims) begin
      r.data_addr  = 38'(row + dim);
      r.scale_addr = 38'(base + PageTokens * RowBytes + 64'(loc % PageTokens) * ScaleBytes
                         + dim / BlockDims);
      r.value_bits = fp8_to_bf16(lo, scale);
    end else begin
      r.data_addr  = 38'(row + Fp8Dims + 2 * (64'(dim) - Fp8Dims));
      r.scale_addr = '0;
      v = {hi, lo};
      r.value_bits = (v[14:7] == 8'hFF && v[6:0] != 0) ? Bf16QNan : v;
    end
    return r;
  endfunction

  // send one element, after an optional gap of idle cycles
  task automatic send_element(logic [23:0] loc, logic [8:0] dim, logic [7:0] lo,
                              logic [7:0] hi, logic [7:0] scale, int gap);
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    loc_i <= loc; dim_i <= dim; elem_lo_i <= lo; elem_hi_i <= hi; scale_exp_i <= scale;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    sb.note_input(predict_element(loc, dim, lo, hi, scale));
  endtask

  task automatic end_burst();
    valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // wait for drain, then write the stride register
  task automatic write_stride(logic [StrideW-1:0] s);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= s;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    stride_model = s;
  endtask

  // random element, biased toward fp8 dims and interesting scale exponents
  task automatic random_element(int gap);
    logic [8:0] dim;
    logic [7:0] scale;
    dim = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(448, 511))
                                      : 9'($urandom_range(0, 447));
    case ($urandom_range(0, 3))
      0: scale = 8'($urandom_range(0, 255));
      1: scale = 8'($urandom_range(100, 150));
      2: scale = 8'($urandom_range(0, 12));
      default: scale = 8'($urandom_range(240, 255));
    endcase
    send_element(24'($urandom), dim, 8'($urandom), 8'($urandom), scale, gap);
  endtask

  // receiver stall pattern, with one long hold-off
  always @(posedge clk_i) begin
    if (hold_off) stall_i <= 1'b1;
    else if (cycles % 200 < 60) stall_i <= 1'b0;
    else stall_i <= ($urandom_range(0, 3) == 0);
  end

  // output check
  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i)
      sb.check_result('{data_addr_o, scale_addr_o, value_bits_o});
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 200000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // long receiver hold-off inside the first random phase, sender keeps offering
  initial begin
    @(posedge rst_ni);
    repeat (100) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (80) @(posedge clk_i);
    hold_off = 1'b0;
  end

  initial begin
    logic [StrideW-1:0] strides [4];
    int burst;
    strides = '{20'd37376, 20'hFFFFF, 20'd0, 20'd12345};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, zeros, NaNs, overflow, tiny, bf16 dims
    send_element(24'd0, 9'd0, 8'h00, 8'h00, 8'd127, 0);
    send_element(24'hFFFFFF, 9'd511, 8'hFF, 8'hFF, 8'hFF, 0);
    send_element(24'd63, 9'd447, 8'h80, 8'h00, 8'd127, 0);
    send_element(24'd64, 9'd448, 8'h80, 8'h3F, 8'd0, 0);
    send_element(24'd1, 9'd1, 8'h7F, 8'h00, 8'd127, 0);
    send_element(24'd1, 9'd2, 8'hFF, 8'h00, 8'd127, 0);
    send_element(24'd2, 9'd3, 8'h01, 8'h00, 8'hFF, 0);
    send_element(24'd3, 9'd64, 8'h7E, 8'h00, 8'd254, 0);
    send_element(24'd3, 9'd65, 8'hFE, 8'h00, 8'd200, 0);
    send_element(24'd4, 9'd128, 8'h01, 8'h00, 8'd0, 0);
    send_element(24'd4, 9'd129, 8'h81, 8'h00, 8'd20, 0);
    send_element(24'd5, 9'd200, 8'h0F, 8'h00, 8'd1, 0);
    send_element(24'd5, 9'd300, 8'h3B, 8'h00, 8'd126, 0);
    send_element(24'd6, 9'd449, 8'h01, 8'h7F, 8'd5, 0);
    send_element(24'd6, 9'd450, 8'h80, 8'h7F, 8'd5, 0);
    send_element(24'd7, 9'd500, 8'h00, 8'hFF, 8'd5, 0);
    send_element(24'd7, 9'd510, 8'h01, 8'h00, 8'd5, 0);
    end_burst();

    // random phases across stride settings
    for (int ph = 0; ph < 4; ph++) begin
      write_stride(strides[ph]);
      for (int n = 0; n < 125; ) begin
        burst = $urandom_range(1, 20);
        for (int k = 0; k < burst && n < 125; k++, n++)
          random_element((k == 0) ? $urandom_range(0, 6) : 0);
        end_burst();
      end
    end

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
